FILE: sv/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared sizes, register indexes, state codes and control types of the
// direct convolution engine.
// ----------------------------------------------------------------------------
package dce_pkg;

  localparam int MAX_KERNEL   = 32;
  localparam int MAX_SIGNAL   = 32;
  localparam int SAMPLE_W     = 16;
  localparam int LEN_W        = 6;
  localparam int IDX_W        = 6;
  localparam int VALUE_W      = 37;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int KADDR_W      = $clog2(MAX_KERNEL);
  localparam int SADDR_W      = $clog2(MAX_SIGNAL);
  localparam int RESULT_LIMIT = 63;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_TDATA_W  = ((IDX_W + VALUE_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KLEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SLEN = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } mac_stat_t;

endpackage

FILE: sv/direct_convolution_engine_unit.sv
// ----------------------------------------------------------------------------
// direct_convolution_engine_unit
// Direct-sum linear or circular convolution of a signal frame with a stored
// kernel from two sample memories, one multiply-accumulate per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Kernel loads and non-final signal loads are taken only while idle.
// The final signal load starts a frame: every tap of every output is summed
// (kernel_length*signal_length products in all) through the read/multiply/
// accumulate pipeline; the frame ends before the next item is taken.
// Results stall on out_tready.
// Reset: mode 0, lengths 32/32, pointers 0, kernel valid bits cleared at once.
module direct_convolution_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dce_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample
  input  logic                               in_tuser,   // [0] action
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dce_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [5:0] out_index, [42:6] out_value
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dce_pkg::LEN_W-1:0]          cfg_data
);
  import dce_pkg::*;

  logic [SAMPLE_W-1:0] kmem [MAX_KERNEL];
  logic [SAMPLE_W-1:0] smem [MAX_SIGNAL];
  logic [MAX_KERNEL-1:0] kvalid_r;

  logic             mode_r;
  logic [LEN_W-1:0] klen_r;
  logic [LEN_W-1:0] slen_r;
  logic [LEN_W-1:0] nk;
  logic [LEN_W-1:0] ns;
  logic [IDX_W-1:0] total;
  logic [IDX_W:0]   tot_w;

  logic [KADDR_W-1:0] kp_r;
  logic [SADDR_W-1:0] sp_r;
  logic [KADDR_W-1:0] kp_eff;
  logic [SADDR_W-1:0] sp_eff;
  logic               in_acc;
  logic               frame_go;

  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0]   n_r;
  logic [LEN_W-1:0]   cnt_r;
  logic [KADDR_W-1:0] ker_addr_r;
  logic [SADDR_W-1:0] sig_addr_r;
  logic               first_r;
  logic               step_last;
  logic               frame_last;
  logic               stall;
  logic               rd_en;

  logic [IDX_W-1:0]   n_set;
  logic [IDX_W:0]     n1_w;
  logic [IDX_W:0]     lo_w;
  logic [IDX_W:0]     hi_w;
  logic [KADDR_W-1:0] ker_set;
  logic [SADDR_W-1:0] sig_set;
  logic [LEN_W-1:0]   cnt_set;

  logic                v1_r;
  logic                first1_r;
  logic                last1_r;
  logic [SAMPLE_W-1:0] ker_rd_r;
  logic [SAMPLE_W-1:0] sig_rd_r;
  logic                kv_rd_r;
  mac_ctrl_t           mac_ctrl;
  mac_stat_t           mac_stat;
  logic signed [VALUE_W-1:0] res_value;

  logic               out_v_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [VALUE_W-1:0] out_val_r;
  logic               out_last_r;
  logic [IDX_W-1:0]   res_n_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      klen_r <= LEN_W'(MAX_KERNEL);
      slen_r <= LEN_W'(MAX_SIGNAL);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[0];
        REG_KLEN: klen_r <= cfg_data;
        REG_SLEN: slen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (klen_r == '0) nk = LEN_W'(1);
    else if (klen_r > LEN_W'(MAX_KERNEL)) nk = LEN_W'(MAX_KERNEL);
    else nk = klen_r;
    if (slen_r == '0) ns = LEN_W'(1);
    else if (slen_r > LEN_W'(MAX_SIGNAL)) ns = LEN_W'(MAX_SIGNAL);
    else ns = slen_r;
    tot_w = mode_r ? {1'b0, ns} : ({1'b0, ns} + {1'b0, nk} - (IDX_W + 1)'(1));
    total = (tot_w > (IDX_W + 1)'(RESULT_LIMIT)) ? IDX_W'(RESULT_LIMIT) : tot_w[IDX_W-1:0];
  end

  // sample loads
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign kp_eff    = ({1'b0, kp_r} >= nk) ? '0 : kp_r;
  assign sp_eff    = ({1'b0, sp_r} >= ns) ? '0 : sp_r;
  assign frame_go  = in_acc && in_tuser && (({1'b0, sp_eff} + LEN_W'(1)) >= ns);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      sp_r     <= '0;
      kvalid_r <= '0;
    end else if (in_acc) begin
      if (!in_tuser) begin
        kvalid_r[kp_eff] <= 1'b1;
        kp_r <= (({1'b0, kp_eff} + LEN_W'(1)) >= nk) ? '0 : kp_eff + KADDR_W'(1);
      end else begin
        sp_r <= frame_go ? '0 : sp_eff + SADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser) begin
      kmem[kp_eff] <= in_tdata;
    end
    if (in_acc && in_tuser) begin
      smem[sp_eff] <= in_tdata;
    end
    if (rd_en) begin
      ker_rd_r <= kmem[ker_addr_r];
      kv_rd_r  <= kvalid_r[ker_addr_r];
      sig_rd_r <= smem[sig_addr_r];
    end
  end

  // sequencer
  assign stall      = out_v_r && !out_tready;
  assign rd_en      = (state_r == ST_MAC) && !stall;
  assign step_last  = (cnt_r == LEN_W'(1));
  assign frame_last = (({1'b0, n_r} + (IDX_W + 1)'(1)) == {1'b0, total});

  always_comb begin
    n_set = (state_r == ST_IDLE) ? '0 : n_r + IDX_W'(1);
    n1_w  = {1'b0, n_set} + (IDX_W + 1)'(1);
    lo_w  = (n1_w > {1'b0, nk}) ? n1_w - {1'b0, nk} : '0;
    hi_w  = ({1'b0, n_set} < ({1'b0, ns} - (IDX_W + 1)'(1))) ? {1'b0, n_set}
                                                            : {1'b0, ns} - (IDX_W + 1)'(1);
    if (mode_r) begin
      sig_set = n_set[SADDR_W-1:0];
      ker_set = '0;
      cnt_set = nk;
    end else begin
      sig_set = lo_w[SADDR_W-1:0];
      ker_set = KADDR_W'({1'b0, n_set} - lo_w);
      cnt_set = LEN_W'(hi_w - lo_w + (IDX_W + 1)'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (frame_go) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (!stall && step_last && frame_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_r && !mac_stat.busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      cnt_r   <= '0;
      first_r <= 1'b0;
    end else if (state_r == ST_IDLE) begin
      if (frame_go) begin
        n_r        <= '0;
        cnt_r      <= cnt_set;
        ker_addr_r <= ker_set;
        sig_addr_r <= sig_set;
        first_r    <= 1'b1;
      end
    end else if (rd_en) begin
      first_r <= step_last;
      if (step_last) begin
        if (frame_last) begin
          cnt_r <= '0;
        end else begin
          n_r        <= n_set;
          cnt_r      <= cnt_set;
          ker_addr_r <= ker_set;
          sig_addr_r <= sig_set;
        end
      end else begin
        cnt_r <= cnt_r - LEN_W'(1);
        if (mode_r) begin
          ker_addr_r <= ker_addr_r + KADDR_W'(1);
          sig_addr_r <= (sig_addr_r == '0) ? SADDR_W'(ns - LEN_W'(1))
                                           : sig_addr_r - SADDR_W'(1);
        end else begin
          ker_addr_r <= ker_addr_r - KADDR_W'(1);
          sig_addr_r <= sig_addr_r + SADDR_W'(1);
        end
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      first1_r <= first_r;
      last1_r  <= step_last;
    end
  end

  assign mac_ctrl.valid = v1_r;
  assign mac_ctrl.first = first1_r;
  assign mac_ctrl.last  = last1_r;

  dce_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .stall     (stall),
    .ctrl      (mac_ctrl),
    .ker_smp   (kv_rd_r ? ker_rd_r : '0),
    .sig_smp   (sig_rd_r),
    .stat      (mac_stat),
    .res_value (res_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      res_n_r <= '0;
    end else begin
      if (frame_go) begin
        res_n_r <= '0;
      end else if (mac_stat.res_valid) begin
        res_n_r <= res_n_r + IDX_W'(1);
      end
      if (mac_stat.res_valid) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_stat.res_valid) begin
      out_idx_r  <= res_n_r;
      out_val_r  <= res_value;
      out_last_r <= (({1'b0, res_n_r} + (IDX_W + 1)'(1)) == {1'b0, total});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - VALUE_W){1'b0}}, out_val_r, out_idx_r};

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!v1_r && !mac_stat.busy))
    else $error("pipeline busy while idle");

  a_mac_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (cnt_r != '0 && {1'b0, n_r} < {1'b0, total}))
    else $error("sequencer count out of range");

  a_res_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    mac_stat.res_valid |-> (state_r != ST_IDLE))
    else $error("result outside a frame");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (mac_stat.res_valid && (({1'b0, res_n_r} + (IDX_W + 1)'(1)) == {1'b0, total}))
      |=> (state_r == ST_DRAIN))
    else $error("final result before sequencer finished");

endmodule

FILE: sv/dce_mac.sv
// ----------------------------------------------------------------------------
// dce_mac
// Product register and accumulator of the convolution datapath; flags the
// finished sum of each output.
// ----------------------------------------------------------------------------
module dce_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  stall,
  input  dce_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [dce_pkg::SAMPLE_W-1:0]   ker_smp,
  input  logic signed [dce_pkg::SAMPLE_W-1:0]   sig_smp,
  output dce_pkg::mac_stat_t                    stat,
  output logic signed [dce_pkg::VALUE_W-1:0]    res_value
);
  import dce_pkg::*;

  logic                       v2_r;
  logic                       first2_r;
  logic                       last2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [VALUE_W-1:0]  acc_r;
  logic signed [VALUE_W-1:0]  prod_ext;
  logic signed [VALUE_W-1:0]  acc_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (!stall) begin
      v2_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      first2_r <= ctrl.first;
      last2_r  <= ctrl.last;
      prod_r   <= ker_smp * sig_smp;
      if (v2_r) begin
        acc_r <= res_value;
      end
    end
  end

  assign prod_ext  = {{(VALUE_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_base  = first2_r ? '0 : acc_r;
  assign res_value = acc_base + prod_ext;

  assign stat.busy      = v2_r;
  assign stat.res_valid = v2_r && last2_r && !stall;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for direct_convolution_engine_unit. A scoreboard keeps
// its own kernel and signal stores, pointers and length registers, and builds
// the expected result frame whenever a signal item completes one. A short
// directed part covers sample extremes, both modes, lengths of zero and above
// the maximum, a kernel longer than the signal and a pointer restart. Random
// phases follow, each with some settings redrawn, a kernel load and whole signal frames
// mixed with stray kernel items and partial frames. Both stream sides idle at
// random and the output side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import dce_pkg::*;

  localparam logic   ACT_KERNEL    = 1'b0;
  localparam logic   ACT_SIGNAL    = 1'b1;
  localparam int     ITEM_TARGET   = 160;
  localparam int     MIN_PHASES    = 6;
  localparam int     SETTLE_CYCLES = 20;
  localparam int     DRAIN_CYCLES  = 50;
  localparam int     HOLD_CYCLES   = 1500;
  localparam longint LIMIT_CYCLES  = 10000000;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } conv_result_t;

  class conv_scoreboard;
    logic signed [SAMPLE_W-1:0] taps [MAX_KERNEL];
    logic signed [SAMPLE_W-1:0] samples [MAX_SIGNAL];
    int unsigned                tap_ptr;
    int unsigned                sample_ptr;
    logic                       circular;
    logic [LEN_W-1:0]           klen;
    logic [LEN_W-1:0]           slen;
    conv_result_t               expected_results [$];

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (samples[i]) samples[i] = '0;
      tap_ptr    = 0;
      sample_ptr = 0;
      circular   = 1'b0;
      klen       = LEN_W'(MAX_KERNEL);
      slen       = LEN_W'(MAX_SIGNAL);
    endfunction

    function int unsigned clamp_len(logic [LEN_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      case (idx)
        REG_MODE: circular = val[0];
        REG_KLEN: klen = val;
        REG_SLEN: slen = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic act, logic [SAMPLE_W-1:0] smp);
      int unsigned  nk, ns, total, n, k, lo, hi;
      longint       acc;
      conv_result_t r;
      nk = clamp_len(klen, MAX_KERNEL);
      ns = clamp_len(slen, MAX_SIGNAL);
      if (act == ACT_KERNEL) begin
        if (tap_ptr >= nk) tap_ptr = 0;
        taps[tap_ptr] = smp;
        tap_ptr = (tap_ptr + 1 >= nk) ? 0 : tap_ptr + 1;
        return;
      end
      if (sample_ptr >= ns) sample_ptr = 0;
      samples[sample_ptr] = smp;
      if (sample_ptr + 1 < ns) begin
        sample_ptr++;
        return;
      end
      sample_ptr = 0;
      total = circular ? ns : ns + nk - 1;
      if (total > RESULT_LIMIT) total = RESULT_LIMIT;
      for (n = 0; n < total; n++) begin
        acc = 0;
        if (circular) begin
          for (k = 0; k < nk; k++)
            acc += longint'(taps[k]) * longint'(samples[(n + ns * nk - k) % ns]);
        end else begin
          lo = (n + 1 > nk) ? n + 1 - nk : 0;
          hi = (n < ns - 1) ? n : ns - 1;
          for (k = lo; k <= hi; k++)
            acc += longint'(samples[k]) * longint'(taps[n - k]);
        end
        r.index = IDX_W'(n);
        r.value = acc[VALUE_W-1:0];
        r.last  = (n + 1 == total);
        expected_results.push_back(r);
      end
    endfunction

    function string check_result(logic [IDX_W-1:0] index, logic [VALUE_W-1:0] value,
                                 logic last);
      conv_result_t want;
      string        msg;
      if (expected_results.size() == 0)
        return $sformatf("unexpected result index %0d value %0d", index, $signed(value));
      want = expected_results.pop_front();
      msg = "";
      if (index !== want.index)
        msg = {msg, $sformatf(" index %0d exp %0d", index, want.index)};
      if (value !== want.value)
        msg = {msg, $sformatf(" value %0d exp %0d", $signed(value), $signed(want.value))};
      if (last !== want.last)
        msg = {msg, $sformatf(" last %0b exp %0b", last, want.last)};
      if (msg != "") msg = {$sformatf("result %0d:", want.index), msg};
      return msg;
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata;   // [15:0] sample
  logic                   in_tuser;   // [0] action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [5:0] out_index, [42:6] out_value
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LEN_W-1:0]       cfg_data;

  conv_scoreboard sb;
  int             errors;
  int             items_sent;
  int             frames_seen;
  longint         cycles;
  bit             no_gaps;

  direct_convolution_engine_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : result_monitor
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_result(out_tdata[IDX_W-1:0], out_tdata[IDX_W+VALUE_W-1:IDX_W], out_tlast);
      if (msg != "") report(msg);
      if (out_tlast) frames_seen++;
    end
  end

  // output side: random ready stretches, one long hold while items are offered
  initial begin : result_sink
    int run;
    bit held;
    bit rdy;
    run  = 0;
    held = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && frames_seen >= 3 && out_tvalid && in_tvalid) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        run = 0;
      end
      if (run == 0) begin
        rdy = ($urandom_range(0, 2) != 0);
        if (rdy)
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        else
          run = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_tready <= rdy;
      end
      run--;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return LEN_W'($urandom_range(1, 6));
    if (r < 16) return LEN_W'($urandom_range(7, 32));
    if (r == 16) return LEN_W'(32);
    if (r == 17) return '0;
    return LEN_W'($urandom_range(33, 63));
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_W'($urandom_range(0, 7)) - 16'd4;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= smp;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(act, smp);
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle(input int settle);
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : stimulus
    int nk, ns, loads, phases;
    sb          = new();
    errors      = 0;
    items_sent  = 0;
    frames_seen = 0;
    cycles      = 0;
    no_gaps     = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // linear, sample extremes
    write_reg(REG_MODE, 6'd0);
    write_reg(REG_KLEN, 6'd3);
    write_reg(REG_SLEN, 6'd4);
    send_item(ACT_KERNEL, 16'h7FFF);
    send_item(ACT_KERNEL, 16'h8000);
    send_item(ACT_KERNEL, 16'h0001);
    send_item(ACT_SIGNAL, 16'h8000);
    send_item(ACT_SIGNAL, 16'h7FFF);
    send_item(ACT_SIGNAL, 16'h0000);
    send_item(ACT_SIGNAL, 16'hFFFF);

    // circular, kernel longer than signal, largest sums
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_MODE, 6'd1);
    write_reg(REG_KLEN, 6'd5);
    write_reg(REG_SLEN, 6'd3);
    repeat (5) send_item(ACT_KERNEL, 16'h8000);
    repeat (3) send_item(ACT_SIGNAL, 16'h8000);

    // lengths above the maximum and zero: 32 taps, one sample
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_MODE, 6'd0);
    write_reg(REG_KLEN, 6'd63);
    write_reg(REG_SLEN, 6'd0);
    send_item(ACT_KERNEL, 16'h7FFF);
    send_item(ACT_SIGNAL, 16'h8000);

    // kernel pointer now past the shortened length
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_MODE, 6'd1);
    write_reg(REG_KLEN, 6'd0);
    write_reg(REG_SLEN, 6'd2);
    send_item(ACT_KERNEL, 16'h1234);
    send_item(ACT_SIGNAL, 16'hAAAA);
    send_item(ACT_SIGNAL, 16'h5555);

    phases = 0;
    while (items_sent < ITEM_TARGET || phases < MIN_PHASES) begin
      wait_idle(SETTLE_CYCLES);
      if ($urandom_range(0, 2) != 0) write_reg(REG_MODE, LEN_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) write_reg(REG_KLEN, pick_len());
      if ($urandom_range(0, 2) != 0) write_reg(REG_SLEN, pick_len());
      no_gaps = ($urandom_range(0, 3) == 0);
      nk = sb.clamp_len(sb.klen, MAX_KERNEL);
      ns = sb.clamp_len(sb.slen, MAX_SIGNAL);
      loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nk + 3) : nk;
      repeat (loads) send_item(ACT_KERNEL, rand_sample());
      repeat ($urandom_range(1, 3)) begin
        repeat (ns) begin
          if ($urandom_range(0, 15) == 0) send_item(ACT_KERNEL, rand_sample());
          send_item(ACT_SIGNAL, rand_sample());
        end
      end
      if (ns > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, ns - 1)) send_item(ACT_SIGNAL, rand_sample());
      phases++;
    end

    wait_idle(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
